// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the list block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define BCL_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked on the next cycle
`define BCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bcl_pkg
// types and constants of the bounded compacting list
// ----------------------------------------------------------------------------
`default_nettype none

package bcl_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int INDEX_W = 5;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;
  localparam int ERR_W   = 2;
  localparam int SEL_W   = $clog2(DEPTH);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND   = 3'd0,
    FN_GET      = 3'd1,
    FN_SET      = 3'd2,
    FN_DELETE   = 3'd3,
    FN_CONTAINS = 3'd4
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/bcl_channels.sv =====
// ----------------------------------------------------------------------------
// bcl channels
// request, response and configuration channels of the list block
// ----------------------------------------------------------------------------
`default_nettype none

interface bcl_req_if;
  logic                          valid;
  logic                          ready;
  logic [bcl_pkg::FUNC_W-1:0]    func;
  logic [bcl_pkg::INDEX_W-1:0]   index;
  logic [bcl_pkg::DATA_W-1:0]    data_in;

  modport source (output valid, func, index, data_in, input ready);
  modport sink   (input valid, func, index, data_in, output ready);
endinterface

interface bcl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bcl_pkg::DATA_W-1:0]    data_out;
  logic                          found;
  logic [bcl_pkg::COUNT_W-1:0]   count;
  logic [bcl_pkg::ERR_W-1:0]     error_code;

  modport source (output valid, data_out, found, count, error_code, input ready);
  modport sink   (input valid, data_out, found, count, error_code, output ready);
endinterface

interface bcl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bcl_pkg::CAP_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/bcl_cell.sv =====
// ----------------------------------------------------------------------------
// bcl_cell
// one list slot: holds a word, loads, takes its upper neighbor, compares
// ----------------------------------------------------------------------------
`default_nettype none

module bcl_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bcl_pkg::cell_ctrl_t        ctrl,
  input  wire logic [bcl_pkg::DATA_W-1:0] din,
  input  wire logic [bcl_pkg::DATA_W-1:0] upper_word,
  output logic      [bcl_pkg::DATA_W-1:0] word,
  output logic                            match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (ctrl.load) begin
      word <= din;
    end else if (ctrl.shift) begin
      word <= upper_word;
    end
  end

  assign match = (word == din);

endmodule

`default_nettype wire

// ===== sv/bounded_compacting_list.sv =====
// ----------------------------------------------------------------------------
// bounded_compacting_list
// bounded list of words kept packed from slot 0, with a row of slot cells
// ----------------------------------------------------------------------------
// One request is taken per cycle while the output register is empty or being
// drained, and its response appears in the output register on the next cycle.
// Every slot cell compares and shifts in the same cycle, so append, get, set,
// delete and contains each complete on the edge that accepts the request.
// Configuration writes are always accepted. The list is empty after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_compacting_list (
  input  wire logic clk,
  input  wire logic rst,
  bcl_req_if.sink   req,
  bcl_rsp_if.source rsp,
  bcl_cfg_if.sink   cfg
);

  `include "assert_macros.svh"

  logic [bcl_pkg::CAP_W-1:0]   capacity;
  logic [bcl_pkg::COUNT_W-1:0] live_count;
  logic [bcl_pkg::COUNT_W-1:0] live_count_next;
  logic [bcl_pkg::COUNT_W-1:0] cap_eff;

  logic [bcl_pkg::DATA_W-1:0]  words [bcl_pkg::DEPTH];
  logic [bcl_pkg::DEPTH-1:0]   match;
  logic [bcl_pkg::DEPTH-1:0]   live;
  logic [bcl_pkg::DEPTH-1:0]   tail_zero;
  bcl_pkg::cell_ctrl_t         ctrl [bcl_pkg::DEPTH];

  logic accept;
  logic full;
  logic in_range;
  logic do_append;
  logic do_set;
  logic do_delete;

  logic [bcl_pkg::DATA_W-1:0]  dout_c;
  logic                        found_c;
  bcl_pkg::err_t               err_c;

  logic                        rsp_valid;
  logic [bcl_pkg::DATA_W-1:0]  rsp_data;
  logic                        rsp_found;
  logic [bcl_pkg::COUNT_W-1:0] rsp_count;
  logic [bcl_pkg::ERR_W-1:0]   rsp_err;

  // config register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bcl_pkg::CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.data;
    end
  end

  assign cap_eff = (bcl_pkg::COUNT_W'(capacity) > bcl_pkg::COUNT_W'(bcl_pkg::DEPTH))
                   ? bcl_pkg::COUNT_W'(bcl_pkg::DEPTH) : bcl_pkg::COUNT_W'(capacity);

  // request decode
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (live_count >= cap_eff);
  assign in_range  = (bcl_pkg::COUNT_W'(req.index) < live_count);

  assign do_append = accept && (req.func == bcl_pkg::FN_APPEND) && !full;
  assign do_set    = accept && (req.func == bcl_pkg::FN_SET) && in_range;
  assign do_delete = accept && (req.func == bcl_pkg::FN_DELETE) && in_range;

  // slot cells
  for (genvar i = 0; i < bcl_pkg::DEPTH; i++) begin : g_cell
    logic [bcl_pkg::DATA_W-1:0] upper;

    if (i == bcl_pkg::DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = words[i+1];
    end

    assign live[i]       = (bcl_pkg::COUNT_W'(i) < live_count);
    assign tail_zero[i]  = live[i] || (words[i] == '0);
    assign ctrl[i].load  = (do_append && (live_count == bcl_pkg::COUNT_W'(i)))
                           || (do_set && (req.index == bcl_pkg::INDEX_W'(i)));
    assign ctrl[i].shift = do_delete && (req.index <= bcl_pkg::INDEX_W'(i));

    bcl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl[i]),
      .din        (req.data_in),
      .upper_word (upper),
      .word       (words[i]),
      .match      (match[i])
    );
  end

  // response
  always_comb begin
    dout_c          = '0;
    found_c         = 1'b0;
    err_c           = bcl_pkg::ERR_OK;
    live_count_next = live_count;
    unique case (req.func)
      bcl_pkg::FN_APPEND: begin
        if (full) begin
          err_c = bcl_pkg::ERR_FULL;
        end else begin
          dout_c          = req.data_in;
          live_count_next = live_count + bcl_pkg::COUNT_W'(1);
        end
      end
      bcl_pkg::FN_GET: begin
        if (!in_range) begin
          err_c = bcl_pkg::ERR_RANGE;
        end else begin
          dout_c = words[req.index[bcl_pkg::SEL_W-1:0]];
        end
      end
      bcl_pkg::FN_SET: begin
        if (!in_range) begin
          err_c = bcl_pkg::ERR_RANGE;
        end else begin
          dout_c = req.data_in;
        end
      end
      bcl_pkg::FN_DELETE: begin
        if (!in_range) begin
          err_c = bcl_pkg::ERR_RANGE;
        end else begin
          dout_c          = words[req.index[bcl_pkg::SEL_W-1:0]];
          live_count_next = live_count - bcl_pkg::COUNT_W'(1);
        end
      end
      bcl_pkg::FN_CONTAINS: begin
        found_c = |(match & live);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      rsp_valid  <= 1'b0;
    end else if (accept) begin
      live_count <= live_count_next;
      rsp_valid  <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data  <= dout_c;
      rsp_found <= found_c;
      rsp_count <= live_count_next;
      rsp_err   <= err_c;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.data_out   = rsp_data;
  assign rsp.found      = rsp_found;
  assign rsp.count      = rsp_count;
  assign rsp.error_code = rsp_err;

  // checks
  `BCL_ASSERT_ALWAYS(a_count_bound, clk, rst, live_count <= bcl_pkg::COUNT_W'(bcl_pkg::DEPTH), "live count above depth")
  `BCL_ASSERT_ALWAYS(a_tail_zero, clk, rst, &tail_zero, "slot above live count not zero")
  `BCL_ASSERT_NEXT(a_err_hold, clk, rst, accept && (err_c != bcl_pkg::ERR_OK), live_count == $past(live_count), "count changed on error")
  `BCL_ASSERT_ALWAYS(a_found_live, clk, rst, !(rsp_valid && rsp_found) || (rsp_count != '0), "found on empty list")

endmodule

`default_nettype wire
